// File: src/sawtooth_am_tremolo_assert.svh
// Assertion macros shared by the RTL; each expects clk and rst_n in scope.
`ifndef SAWTOOTH_AM_TREMOLO_ASSERT_SVH
`define SAWTOOTH_AM_TREMOLO_ASSERT_SVH

`define SAT_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define SAT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SAT_IMPLY_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sat_pkg.sv
package sat_pkg;

    localparam int unsigned TABLE_SIZE     = 131072;
    localparam int unsigned SAMPLE_RATE_HZ = 44100;

    localparam int TS_LOG       = $clog2(TABLE_SIZE);
    localparam int PHASE_W      = TS_LOG + 16;
    localparam int RATE_W       = 32;
    localparam int RATE_IDX_W   = 8;
    localparam int RATE_ROM_DEPTH = 1 << RATE_IDX_W;
    localparam int SAMPLE_W     = 16;
    localparam int LEVEL_CODE_W = 8;
    localparam int LEVEL_W      = 17;
    localparam int MAG_W        = SAMPLE_W + 1;
    localparam int K_W          = 20;

    localparam logic [PHASE_W-1:0] PHASE_SPAN = PHASE_W'(64'(TABLE_SIZE - 1) << 16);
    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1 << 16);
    localparam logic [K_W-1:0]     SMOOTH_K   = K_W'(858993);
    localparam logic [MAG_W-1:0]   CLIP_MAX   = MAG_W'(32767);

    // phase increment = floor(rate * 2^NUM_SHIFT / SAMPLE_RATE_HZ), taken as
    // (rate * INC_MAGIC) >> INC_S from two partial products
    localparam int NUM_SHIFT  = TS_LOG - 7;
    localparam int DEN_W      = $clog2(SAMPLE_RATE_HZ + 1);
    localparam int INC_S      = RATE_W + DEN_W;
    localparam logic [63:0] INC_MAGIC =
        ((64'd1 << (INC_S + NUM_SHIFT)) + 64'(SAMPLE_RATE_HZ - 1)) / 64'(SAMPLE_RATE_HZ);
    localparam int MAGIC_W    = $clog2(INC_MAGIC + 64'd1);
    localparam int MAGIC_LO_W = (MAGIC_W + 1) / 2;
    localparam int MAGIC_HI_W = MAGIC_W - MAGIC_LO_W;
    localparam logic [MAGIC_LO_W-1:0] MAGIC_LO = MAGIC_LO_W'(INC_MAGIC);
    localparam logic [MAGIC_HI_W-1:0] MAGIC_HI = MAGIC_HI_W'(INC_MAGIC >> MAGIC_LO_W);
    localparam int MUL_B_W    = (MAGIC_LO_W > K_W) ? MAGIC_LO_W : K_W;
    localparam int PROD_W     = RATE_W + MUL_B_W;
    localparam int INC_SHIFT  = INC_S - MAGIC_LO_W;
    localparam int INC_W      = PROD_W - INC_SHIFT;

    localparam logic [63:0] LN2_Q32 = 64'd2977044471;

    function automatic logic [63:0] div_by_small(input logic [63:0] v, input int unsigned n);
        logic [63:0] q;
        case (n)
            1:  q = v / 64'd1;
            2:  q = v / 64'd2;
            3:  q = v / 64'd3;
            4:  q = v / 64'd4;
            5:  q = v / 64'd5;
            6:  q = v / 64'd6;
            7:  q = v / 64'd7;
            8:  q = v / 64'd8;
            9:  q = v / 64'd9;
            10: q = v / 64'd10;
            11: q = v / 64'd11;
            12: q = v / 64'd12;
            13: q = v / 64'd13;
            14: q = v / 64'd14;
            15: q = v / 64'd15;
            16: q = v / 64'd16;
            17: q = v / 64'd17;
            18: q = v / 64'd18;
            19: q = v / 64'd19;
            20: q = v / 64'd20;
            21: q = v / 64'd21;
            22: q = v / 64'd22;
            23: q = v / 64'd23;
            24: q = v / 64'd24;
            25: q = v / 64'd25;
            26: q = v / 64'd26;
            27: q = v / 64'd27;
            28: q = v / 64'd28;
            29: q = v / 64'd29;
            30: q = v / 64'd30;
            31: q = v / 64'd31;
            32: q = v / 64'd32;
            33: q = v / 64'd33;
            34: q = v / 64'd34;
            35: q = v / 64'd35;
            36: q = v / 64'd36;
            37: q = v / 64'd37;
            38: q = v / 64'd38;
            39: q = v / 64'd39;
            default: q = v;
        endcase
        return q;
    endfunction

    // 25 * 2^((idx - 127) / 38) Hz in Q9.23, from a truncated exp series
    function automatic logic [RATE_W-1:0] rate_rom_entry(input int unsigned idx);
        int unsigned u;
        int unsigned q;
        int unsigned r;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] scaled;
        logic        done;
        u = (idx & 255) + 25;
        q = u / 38;
        r = u % 38;
        x = (64'(r) * LN2_Q32) / 64'd38;
        term = 64'd1 << 32;
        s = term;
        done = 1'b0;
        for (int unsigned n = 1; n < 40; n++) begin
            if (!done) begin
                term = div_by_small((term * x) >> 32, n);
                if (term == 64'd0) begin
                    done = 1'b1;
                end
                else begin
                    s = s + term;
                end
            end
        end
        scaled = (64'd25 * s) >> (13 - q);
        return scaled[RATE_W-1:0];
    endfunction

endpackage

// File: src/sawtooth_am_tremolo.sv
// Sawtooth tremolo: scales each audio sample by a falling sawtooth LFO level.
// Input channel: sample_in with in_valid / in_stall; a transfer happens at a
// clock edge with in_valid high and in_stall low.
// Output channel: sample_out and level_code with out_valid / out_stall.
// Configuration: cfg_we writes cfg_wdata into the LFO rate index; a zero write
// is dropped. Write only while no sample is in progress.
// Each sample runs through a ten-step microcode program driving one shared
// multiplier; the phase increment is a reciprocal multiply split into two
// partial products. out_valid is registered and rises as the program returns
// to its load step, where the next sample is taken; one sample at a time.
// A finished result waits in the output register; if the receiver stalls,
// the next sample is still accepted and worked on, and the program holds in
// its last step until the output register is free.
// Reset clears the rate index, LFO phase and smoothed rate, drops any pending
// result and leaves the block ready for a sample on the first cycle.
module sawtooth_am_tremolo (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic        [sat_pkg::RATE_IDX_W-1:0]  cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [sat_pkg::SAMPLE_W-1:0]    sample_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [sat_pkg::SAMPLE_W-1:0]    sample_out,
    output logic        [sat_pkg::LEVEL_CODE_W-1:0] level_code
);
    import sat_pkg::*;

    `include "sawtooth_am_tremolo_assert.svh"

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_DIFF,
        OP_MUL_RATE,
        OP_SMOOTH,
        OP_INC_LO,
        OP_INC_HI,
        OP_INC_SUM,
        OP_PHASE,
        OP_MUL_SAMPLE,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_INPUT,
        HOLD_OUT_FULL
    } hold_t;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        op_t   op;
        hold_t hold;
        pc_t   jump;
    } ctrl_word_t;

    localparam pc_t STEP_LOAD       = PC_W'(0);
    localparam pc_t STEP_DIFF       = PC_W'(1);
    localparam pc_t STEP_MUL_RATE   = PC_W'(2);
    localparam pc_t STEP_SMOOTH     = PC_W'(3);
    localparam pc_t STEP_INC_LO     = PC_W'(4);
    localparam pc_t STEP_INC_HI     = PC_W'(5);
    localparam pc_t STEP_INC_SUM    = PC_W'(6);
    localparam pc_t STEP_PHASE      = PC_W'(7);
    localparam pc_t STEP_MUL_SAMPLE = PC_W'(8);
    localparam pc_t STEP_EMIT       = PC_W'(9);

    function automatic ctrl_word_t ucode(input pc_t pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_LOAD:       w = '{OP_LOAD,       HOLD_NO_INPUT, STEP_DIFF};
            STEP_DIFF:       w = '{OP_DIFF,       HOLD_NONE,     STEP_MUL_RATE};
            STEP_MUL_RATE:   w = '{OP_MUL_RATE,   HOLD_NONE,     STEP_SMOOTH};
            STEP_SMOOTH:     w = '{OP_SMOOTH,     HOLD_NONE,     STEP_INC_LO};
            STEP_INC_LO:     w = '{OP_INC_LO,     HOLD_NONE,     STEP_INC_HI};
            STEP_INC_HI:     w = '{OP_INC_HI,     HOLD_NONE,     STEP_INC_SUM};
            STEP_INC_SUM:    w = '{OP_INC_SUM,    HOLD_NONE,     STEP_PHASE};
            STEP_PHASE:      w = '{OP_PHASE,      HOLD_NONE,     STEP_MUL_SAMPLE};
            STEP_MUL_SAMPLE: w = '{OP_MUL_SAMPLE, HOLD_NONE,     STEP_EMIT};
            STEP_EMIT:       w = '{OP_EMIT,       HOLD_OUT_FULL, STEP_LOAD};
            default:         w = '{OP_LOAD,       HOLD_NO_INPUT, STEP_DIFF};
        endcase
        return w;
    endfunction

    logic [RATE_W-1:0] rate_rom [RATE_ROM_DEPTH];

    for (genvar gi = 0; gi < RATE_ROM_DEPTH; gi++) begin : g_rate_rom
        localparam logic [RATE_W-1:0] ENTRY = rate_rom_entry(gi);
        assign rate_rom[gi] = ENTRY;
    end

    // control and LFO state
    pc_t                    pc_reg, pc_next;
    logic [RATE_IDX_W-1:0]  rate_idx_reg;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [RATE_W-1:0]      smooth_reg, smooth_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath
    logic [RATE_W-1:0]      target_reg;
    logic [RATE_W-1:0]      diff_reg;
    logic                   dir_up_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic                   neg_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [RATE_W-1:0]      acc_reg;
    logic [INC_W-1:0]       inc_reg;
    logic [SAMPLE_W-1:0]    sample_out_reg;
    logic [LEVEL_CODE_W-1:0] level_code_reg;

    ctrl_word_t             cw;
    logic                   hold_now;
    logic                   fire;
    logic                   out_full;

    logic [RATE_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [PROD_W-1:0]      mul_p;

    logic [MAG_W-1:0]       sx;
    logic [PROD_W-1:0]      inc_sum;
    logic [PHASE_W:0]       phase_sum;
    logic [K_W-1:0]         smooth_step;
    logic [MAG_W-1:0]       scaled;
    logic [MAG_W-1:0]       clipped;
    logic [SAMPLE_W-1:0]    clip16;
    logic [LEVEL_W+7:0]     lvl_x255;

    logic                   level_ok;
    logic                   smooth_ok;

    assign cw       = ucode(pc_reg);
    assign out_full = out_valid_reg && out_stall;
    assign in_stall = cw.hold != HOLD_NO_INPUT;

    always_comb
    begin
        case (cw.hold)
            HOLD_NONE:     hold_now = 1'b0;
            HOLD_NO_INPUT: hold_now = !in_valid;
            HOLD_OUT_FULL: hold_now = out_full;
            default:       hold_now = 1'b0;
        endcase
        fire    = !hold_now;
        pc_next = hold_now ? pc_reg : cw.jump;
    end

    // shared multiplier
    always_comb
    begin
        case (cw.op)
            OP_MUL_SAMPLE:
            begin
                mul_a = RATE_W'(mag_reg);
                mul_b = MUL_B_W'(level_reg);
            end
            OP_INC_LO:
            begin
                mul_a = smooth_reg;
                mul_b = MUL_B_W'(MAGIC_LO);
            end
            OP_INC_HI:
            begin
                mul_a = smooth_reg;
                mul_b = MUL_B_W'(MAGIC_HI);
            end
            default:
            begin
                mul_a = diff_reg;
                mul_b = MUL_B_W'(SMOOTH_K);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        sx          = {sample_in[SAMPLE_W-1], sample_in};
        inc_sum     = prod_reg + PROD_W'(acc_reg);
        phase_sum   = {1'b0, phase_reg} + (PHASE_W+1)'(inc_reg);
        smooth_step = prod_reg[RATE_W +: K_W];
        scaled      = prod_reg[16 +: MAG_W];
        clipped     = (scaled > CLIP_MAX) ? CLIP_MAX : scaled;
        clip16      = clipped[SAMPLE_W-1:0];
        lvl_x255    = {level_reg, 8'd0} - (LEVEL_W+8)'(level_reg);

        phase_next = phase_reg;
        if (fire && cw.op == OP_PHASE)
        begin
            if (phase_sum >= {1'b0, PHASE_SPAN})
                phase_next = PHASE_W'(phase_sum - {1'b0, PHASE_SPAN});
            else
                phase_next = phase_sum[PHASE_W-1:0];
        end

        smooth_next = smooth_reg;
        if (fire && cw.op == OP_SMOOTH)
        begin
            if (dir_up_reg)
                smooth_next = smooth_reg + RATE_W'(smooth_step);
            else
                smooth_next = smooth_reg - RATE_W'(smooth_step);
        end

        out_valid_next = out_valid_reg;
        if (fire && cw.op == OP_EMIT)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_LOAD;
            rate_idx_reg  <= '0;
            phase_reg     <= '0;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            phase_reg     <= phase_next;
            smooth_reg    <= smooth_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_wdata != '0)
                rate_idx_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            case (cw.op) inside
                OP_LOAD:
                begin
                    level_reg  <= LEVEL_ONE - LEVEL_W'(phase_reg >> TS_LOG);
                    neg_reg    <= sample_in[SAMPLE_W-1];
                    mag_reg    <= sample_in[SAMPLE_W-1] ? MAG_W'(0) - sx : sx;
                    target_reg <= rate_rom[rate_idx_reg];
                end
                OP_DIFF:
                begin
                    dir_up_reg <= target_reg >= smooth_reg;
                    diff_reg   <= (target_reg >= smooth_reg) ? target_reg - smooth_reg
                                                             : smooth_reg - target_reg;
                end
                OP_MUL_RATE, OP_INC_HI, OP_MUL_SAMPLE:
                begin
                    prod_reg <= mul_p;
                end
                OP_INC_LO:
                begin
                    acc_reg <= mul_p[MAGIC_LO_W +: RATE_W];
                end
                OP_INC_SUM:
                begin
                    inc_reg <= inc_sum[INC_SHIFT +: INC_W];
                end
                OP_EMIT:
                begin
                    sample_out_reg <= neg_reg ? SAMPLE_W'(0) - clip16 : clip16;
                    level_code_reg <= lvl_x255[16 +: LEVEL_CODE_W];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign level_code = level_code_reg;

    assign level_ok  = level_reg != '0 && level_reg <= LEVEL_ONE;
    assign smooth_ok = dir_up_reg ? (smooth_reg <= target_reg) : (smooth_reg >= target_reg);

    `SAT_CHECK(a_phase_in_span, phase_reg < PHASE_SPAN, "phase outside its wrap span")
    `SAT_IMPLY(a_inc_in_span, cw.op == OP_PHASE, PHASE_W'(inc_reg) < PHASE_SPAN, "bad increment")
    `SAT_IMPLY_NEXT(a_smooth_bound, fire && cw.op == OP_SMOOTH, smooth_ok, "rate overshoot")
    `SAT_IMPLY(a_level_range, pc_reg != STEP_LOAD, level_ok, "level out of range")
    `SAT_IMPLY_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "sample taken while busy")

endmodule

// File: verif/sawtooth_am_tremolo_tb.sv
module sawtooth_am_tremolo_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sat_pkg::*;

    localparam int STUCK_LIMIT = 3000;
    localparam int HOLD_CYCLES = 240;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [63:0] LN2_Q32_C = 64'd2977044471;
    localparam logic [63:0] SMOOTH_Q32 = 64'd858993;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [LEVEL_CODE_W-1:0]    level;
    } tremolo_out_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [RATE_IDX_W-1:0]         cfg_wdata;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [SAMPLE_W-1:0]    sample_in;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_W-1:0]    sample_out;
    logic [LEVEL_CODE_W-1:0]       level_code;

    // predictor state
    logic [7:0]    rate_sel;
    logic [63:0]   lfo_phase;
    logic [31:0]   lfo_rate;
    logic [16:0]   lfo_level;

    tremolo_out_t  pending_out[$];
    tremolo_out_t  oldest;
    int            mismatches;
    int            samples_sent;
    int            results_seen;
    int            rate_writes;
    int            hold_left;
    bit            calm;

    sawtooth_am_tremolo dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .level_code (level_code)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [31:0] lfo_rate_target(input logic [7:0] idx);
        int unsigned u;
        int unsigned q;
        int unsigned r;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        u = int'(idx) + 25;
        q = u / 38;
        r = u % 38;
        x = (64'(r) * LN2_Q32_C) / 64'd38;
        term = 64'd1 << 32;
        acc = term;
        for (int n = 1; n < 40 && term != 64'd0; n++)
        begin
            term = ((term * x) >> 32) / 64'(n);
            acc = acc + term;
        end
        return 32'((64'd25 * acc) >> (13 - q));
    endfunction

    function automatic tremolo_out_t tremolo_step(input logic signed [SAMPLE_W-1:0] s);
        logic [31:0]  tgt;
        logic [63:0]  inc;
        logic [63:0]  prod;
        int           sx;
        int unsigned  mag;
        tremolo_out_t r;
        lfo_level = 17'(64'd65536 - lfo_phase / 64'(TABLE_SIZE));
        tgt = lfo_rate_target(rate_sel);
        if (tgt >= lfo_rate)
            lfo_rate = lfo_rate + 32'((64'(tgt - lfo_rate) * SMOOTH_Q32) >> 32);
        else
            lfo_rate = lfo_rate - 32'((64'(lfo_rate - tgt) * SMOOTH_Q32) >> 32);
        inc = (64'(lfo_rate) * 64'(TABLE_SIZE)) / (64'(SAMPLE_RATE_HZ) * 64'd128);
        lfo_phase = (lfo_phase + inc) % (64'(TABLE_SIZE - 1) << 16);
        sx = s;
        mag = (sx < 0) ? -sx : sx;
        prod = (64'(mag) * 64'(lfo_level)) >> 16;
        if (prod > 64'd32767)
            prod = 64'd32767;
        r.sample = (sx < 0) ? -16'(prod) : 16'(prod);
        r.level = 8'((64'(lfo_level) * 64'd255) >> 16);
        return r;
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (in_stall);
        pending_out.push_back(tremolo_step(s));
        samples_sent++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(19))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            4: return 16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_rate(input logic [7:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        if (v != 8'd0)
            rate_sel = v;
        rate_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_full_level_extremes();
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd16384);
        send_sample(-16'sd16384);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
    endtask

    task automatic test_rate_index_writes();
        write_rate(8'd255);
        repeat (4) send_sample(pick_sample());
        // a zero write must leave the index alone
        write_rate(8'd0);
        repeat (4) send_sample(pick_sample());
        write_rate(8'd1);
        repeat (4) send_sample(pick_sample());
        write_rate(8'd255);
        send_sample(-16'sd32768);
    endtask

    task automatic test_random_phases();
        logic [7:0] idx;
        for (int p = 0; p < 6; p++)
        begin
            idx = (p < 3) ? 8'd255 : 8'($urandom_range(255));
            write_rate(idx);
            repeat (200) send_sample(pick_sample());
        end
        write_rate(8'd255);
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        repeat (150) send_sample(pick_sample());
        calm = 1'b0;
    endtask

    task automatic test_output_holdoff();
        repeat (20) send_sample(pick_sample());
        hold_left = HOLD_CYCLES;
        repeat (12) send_sample(pick_sample());
        while (hold_left > 0)
            @(posedge clk);
        repeat (60) send_sample(pick_sample());
    endtask

    // receiver: random stall, quiet stretch, or a long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 30);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
            begin
                $display("%0t: unexpected result sample_out=%0d level_code=%0d",
                         $time, sample_out, level_code);
                mismatches++;
            end
            else
            begin
                oldest = pending_out.pop_front();
                results_seen++;
                if (sample_out !== oldest.sample)
                begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, oldest.sample, sample_out);
                    mismatches++;
                end
                if (level_code !== oldest.level)
                begin
                    $display("%0t: level_code expected %0d actual %0d",
                             $time, oldest.level, level_code);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        sample_in = '0;
        calm = 1'b0;
        hold_left = 0;
        mismatches = 0;
        samples_sent = 0;
        results_seen = 0;
        rate_writes = 0;
        rate_sel = 8'd0;
        lfo_phase = '0;
        lfo_rate = '0;
        lfo_level = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_full_level_extremes();
        test_rate_index_writes();
        test_random_phases();
        test_no_idle();
        test_output_holdoff();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d samples sent, %0d results checked, %0d rate writes",
                 samples_sent, results_seen, rate_writes);
        $display("covered full-level extremes, zero-write drop, random rates, output hold-off");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
